// File: src/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define PRT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define PRT_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/prt_pkg.sv
// Types, codes and constants of the page range tracker
package prt_pkg;

	localparam int SLOTS_DEF          = 64;
	localparam int MAX_PAGE_BYTES_DEF = 1048576;
	localparam int QUEUE_DEPTH        = 2;
	localparam int PAGE_W             = 21;
	localparam logic [PAGE_W-1:0] PAGE_BYTES_RST = 21'd65536;

	typedef enum logic [2:0] {
		OP_OCCUPY = 3'd0,
		OP_READ   = 3'd1,
		OP_WRITE  = 3'd2,
		OP_FLUSH  = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE       = 3'd0,
		ST_MISS       = 3'd1,
		ST_HOLE       = 3'd2,
		ST_OUTSIDE    = 3'd3,
		ST_NOT_CACHED = 3'd4
	} status_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  slot;
		logic [63:0] file_id;
		logic [30:0] page_number;
		logic [19:0] byte_offset;
		logic [20:0] byte_count;
		logic        write_back;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [20:0] served_bytes;
		logic        flush_valid;
		logic [19:0] flush_start;
		logic [20:0] flush_length;
		logic [50:0] flush_file_offset;
	} result_t;

	// classified transaction as it travels from front to back
	typedef struct packed {
		item_t item;
		logic  mode_bad;
		logic  slot_bad;
		logic  outside;
	} qentry_t;

	typedef struct packed {
		logic [63:0] tag_file;
		logic [30:0] tag_page;
		logic [19:0] range_start;
		logic [20:0] range_length;
		logic [19:0] dirty_start;
		logic        dirty_mark;
		logic        writeback_mode;
	} slot_entry_t;

endpackage

// File: src/page_range_tracker.sv
// Page range tracker top level: page size register, front end, queue, back end
//
// Keeps tag, valid byte range and dirty span for SLOTS write-back cache pages
// and runs one occupy, read, write, flush or clear per request transaction.
// The front end classifies a request combinationally and registers it, then hands
// it to a two-entry queue. The back end takes a transaction from the queue only
// in BK_IDLE, where it reads the slot entry from the single-port slot memory. In
// BK_EXEC, once the result register is free, it computes the result, writes the
// entry back and loads the result register before it returns to BK_IDLE, so it
// works on one transaction at a time. Write page_bytes only while no transaction
// is in flight.
module page_range_tracker
	import prt_pkg::*;
#(
	parameter int SLOTS          = SLOTS_DEF,
	parameter int MAX_PAGE_BYTES = MAX_PAGE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [PAGE_W-1:0] cfg_wdata,
	input  logic              req_valid,
	output logic              req_ready,
	input  item_t             req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output result_t           rsp
);

	logic [PAGE_W-1:0] page_bytes_q;
	logic              push_valid;
	logic              push_ready;
	qentry_t           push_entry;
	logic              pop_valid;
	logic              pop_ready;
	qentry_t           pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_q <= PAGE_BYTES_RST;
		end else if (cfg_we) begin
			page_bytes_q <= cfg_wdata;
		end
	end

	prt_front #(
		.SLOTS          (SLOTS),
		.MAX_PAGE_BYTES (MAX_PAGE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.page_bytes (page_bytes_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	prt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	prt_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.page_bytes (page_bytes_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

// File: src/prt_front.sv
// Front end: accepts transactions and classifies mode, slot and page bound
module prt_front
	import prt_pkg::*;
#(
	parameter int SLOTS          = SLOTS_DEF,
	parameter int MAX_PAGE_BYTES = MAX_PAGE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  item_t             req,
	input  logic [PAGE_W-1:0] page_bytes,
	output logic              push_valid,
	input  logic              push_ready,
	output qentry_t           push_entry
);

	logic        valid_s1;
	qentry_t     entry_s1;
	qentry_t     cls;
	logic [31:0] limit;

	assign req_ready  = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

	always_comb begin
		limit = (32'(page_bytes) < 32'(MAX_PAGE_BYTES)) ? 32'(page_bytes)
			: 32'(MAX_PAGE_BYTES);
		cls.item     = req;
		cls.mode_bad = req.mode > OP_CLEAR;
		cls.slot_bad = 32'(req.slot) >= 32'(SLOTS);
		cls.outside  = (32'(req.byte_offset) + 32'(req.byte_count)) > limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			entry_s1 <= cls;
		end
	end

endmodule

// File: src/prt_queue.sv
// Short queue between the front end and the back end
module prt_queue
	import prt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  qentry_t push_entry,
	output logic    pop_valid,
	input  logic    pop_ready,
	output qentry_t pop_entry
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qentry_t          buf_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = buf_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: src/prt_back.sv
// Back end: slot table, read-modify-write of one slot and result register
module prt_back
	import prt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PAGE_W-1:0] page_bytes,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  qentry_t           pop_entry,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output result_t           rsp
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	slot_entry_t      mem [SLOTS];
	logic [SLOTS-1:0] used_q;
	back_state_t      state_q;
	back_state_t      state_d;
	qentry_t          cur_q;
	slot_entry_t      ent_q;
	result_t          rsp_q;
	logic             rsp_valid_q;
	logic             out_free;
	logic             exec;
	logic [IDX_W-1:0] pop_idx;
	logic [IDX_W-1:0] cur_idx;

	item_t       it;
	logic        used;
	logic        match;
	logic [21:0] rng_end;
	logic [21:0] acc_end;
	logic [21:0] avail;
	logic [19:0] new_rs;
	logic [21:0] new_re;
	logic        wr_ok;
	logic [51:0] prod;
	result_t     rep;
	result_t     res_d;
	slot_entry_t wr_d;
	logic        wr_en;
	logic        set_used;
	logic        clr_used;

	assign pop_idx   = IDX_W'(pop_entry.item.slot);
	assign cur_idx   = IDX_W'(cur_q.item.slot);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		exec      = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (out_free) begin
					exec    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		it      = cur_q.item;
		used    = used_q[cur_idx];
		match   = used && (ent_q.tag_file == it.file_id) && (ent_q.tag_page == it.page_number);
		rng_end = 22'(ent_q.range_start) + 22'(ent_q.range_length);
		acc_end = 22'(it.byte_offset) + 22'(it.byte_count);
		avail   = rng_end - 22'(it.byte_offset);
		new_rs  = (it.byte_offset < ent_q.range_start) ? it.byte_offset : ent_q.range_start;
		new_re  = (acc_end > rng_end) ? acc_end : rng_end;
		prod    = page_bytes * ent_q.tag_page;
		wr_ok   = 1'b0;

		// dirty span of the slot as it stands
		rep = '0;
		if (ent_q.dirty_mark) begin
			rep.flush_valid       = 1'b1;
			rep.flush_start       = ent_q.dirty_start;
			rep.flush_length      = (rng_end > 22'(ent_q.dirty_start))
				? 21'(rng_end - 22'(ent_q.dirty_start)) : '0;
			rep.flush_file_offset = 51'(prod + 52'(ent_q.dirty_start));
		end

		res_d    = '0;
		wr_d     = ent_q;
		wr_en    = 1'b0;
		set_used = 1'b0;
		clr_used = 1'b0;

		if (cur_q.mode_bad) begin
			res_d = '0;
		end else if (cur_q.slot_bad) begin
			res_d.status = ST_MISS;
		end else begin
			case (it.mode)
				OP_OCCUPY: begin
					if (used) begin
						res_d = rep;
					end
					wr_d                = '0;
					wr_d.tag_file       = it.file_id;
					wr_d.tag_page       = it.page_number;
					wr_d.writeback_mode = it.write_back;
					wr_en               = 1'b1;
					set_used            = 1'b1;
				end
				OP_CLEAR: begin
					if (!used || (it.file_id != '0 && !match)) begin
						res_d.status = ST_MISS;
					end else begin
						res_d    = rep;
						clr_used = 1'b1;
					end
				end
				OP_FLUSH: begin
					if (!match) begin
						res_d.status = ST_MISS;
					end else begin
						res_d            = rep;
						wr_d.dirty_start = '0;
						wr_d.dirty_mark  = 1'b0;
						wr_en            = 1'b1;
					end
				end
				OP_READ: begin
					if (!match) begin
						res_d.status = ST_MISS;
					end else if (cur_q.outside) begin
						res_d.status = ST_OUTSIDE;
					end else if (it.byte_offset < ent_q.range_start
						|| 22'(it.byte_offset) >= rng_end) begin
						res_d.status = ST_NOT_CACHED;
					end else begin
						res_d.served_bytes = (avail < 22'(it.byte_count)) ? 21'(avail)
							: it.byte_count;
					end
				end
				OP_WRITE: begin
					if (!match) begin
						res_d.status = ST_MISS;
					end else if (cur_q.outside) begin
						res_d.status = ST_OUTSIDE;
					end else if (it.byte_count != '0) begin
						if (ent_q.range_length == '0) begin
							wr_d.range_start  = it.byte_offset;
							wr_d.range_length = it.byte_count;
							wr_ok             = 1'b1;
						end else if (acc_end < 22'(ent_q.range_start)
							|| 22'(it.byte_offset) > rng_end) begin
							res_d.status = ST_HOLE;
						end else begin
							wr_d.range_start  = new_rs;
							wr_d.range_length = 21'(new_re - 22'(new_rs));
							wr_ok             = 1'b1;
						end
						if (wr_ok) begin
							if (ent_q.writeback_mode) begin
								if (!ent_q.dirty_mark || ent_q.dirty_start > it.byte_offset) begin
									wr_d.dirty_start = it.byte_offset;
								end
								wr_d.dirty_mark = 1'b1;
							end
							res_d.served_bytes = it.byte_count;
							wr_en              = 1'b1;
						end
					end
				end
				default: res_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec && set_used) begin
				used_q[cur_idx] <= 1'b1;
			end
			if (exec && clr_used) begin
				used_q[cur_idx] <= 1'b0;
			end
			if (exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_q <= pop_entry;
			ent_q <= mem[pop_idx];
		end
		if (exec && wr_en) begin
			mem[cur_idx] <= wr_d;
		end
		if (exec) begin
			rsp_q <= res_d;
		end
	end

endmodule

// File: src/prt_checker.sv
// Port-level checker of the page range tracker, bound to the top level
`include "assert_macros.svh"

module prt_checker
	import prt_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    rsp_valid,
	input logic    rsp_ready,
	input result_t rsp
);

	`PRT_ASSERT_ALWAYS(a_rsp_idle_in_reset, clk, !arst_n |-> !rsp_valid, "response valid during reset")

	`PRT_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "stalled response changed")

	`PRT_ASSERT(a_flush_fields_clear, clk, arst_n, rsp_valid && !rsp.flush_valid |-> rsp.flush_start == '0 && rsp.flush_length == '0 && rsp.flush_file_offset == '0, "flush fields set without flush")

	`PRT_ASSERT(a_error_quiet, clk, arst_n, rsp_valid && rsp.status != ST_DONE |-> rsp.served_bytes == '0 && !rsp.flush_valid, "failed transaction reports data")

endmodule

bind page_range_tracker prt_checker u_prt_checker (.*);
